// File: rtl/activity_boost_extend_timer_top_macros.svh
// Assertion macros shared by the timer RTL.
`ifndef ACTIVITY_BOOST_EXTEND_TIMER_TOP_MACROS_SVH
`define ACTIVITY_BOOST_EXTEND_TIMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ABET_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Check that the consequent holds in the same cycle as the antecedent.
`define ABET_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ABET_ASSERT_ALWAYS(label, cond)
`define ABET_ASSERT_IMPL(label, ante, cons)
`endif

`endif

// File: rtl/abet_pkg.sv
package abet_pkg;

    localparam int BASE_W       = 16;
    localparam int CNT_W        = 20;
    localparam int SHARED_W     = 3;
    localparam int INTERNAL_MAX = 5;
    localparam int SHARED_MAX   = 5;
    localparam int EXT_W        = $clog2(INTERNAL_MAX + 1);
    localparam int TOT_W        = $clog2(INTERNAL_MAX + (1 << SHARED_W));
    localparam int WIDE_W       = BASE_W + TOT_W;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(100);

    typedef enum logic [1:0] {
        MODE_TOUCH   = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_BLANK   = 2'd2,
        MODE_UNBLANK = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORE_BASE  = 1'b0,
        CFG_INPUT_BASE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        mode_t               mode;
        logic [SHARED_W-1:0] shared_pending_core;
        logic [SHARED_W-1:0] shared_pending_input;
    } in_item_t;

    typedef struct packed {
        logic core_active;
        logic input_active;
        logic suspended_flag;
    } out_item_t;

    typedef struct packed {
        logic             on;
        logic [EXT_W-1:0] ext;
        logic [CNT_W-1:0] cnt;
    } chan_t;

endpackage

// File: rtl/activity_boost_extend_timer_top.sv
// Two-channel activity boost timer (core and input channels).
// Input channel (in, in_valid, in_stall): one beat per event: touch, tick,
// display blank or display unblank, plus the shared pending counts of both
// channels, which are read only when a channel expires on a tick.
// Output channel (out, out_valid, out_stall): one beat per input beat with
// the active flags and the suspend flag as they stand after that event.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes the
// base period of the core (index 0) or input (index 1) channel; always ready.
// Output: the result of a beat is registered in the output register, or in
// the skid while the output holds a result. Throughput: one beat per cycle
// while in_stall is low; the state update and the base times pending
// multiply are both combinational between acceptance and the output register.
// Stall: a two-entry output stage (output register plus skid) keeps taking
// beats while one result waits; in_stall rises only once the skid holds a
// result too.
// Reset: all channels off, not suspended, both base periods back to 100,
// no result pending.
`include "activity_boost_extend_timer_top_macros.svh"

module activity_boost_extend_timer_top
    import abet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  in_item_t             in,
    input  logic                 in_valid,
    output logic                 in_stall,
    output out_item_t            out,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_idx_t             cfg_index,
    input  logic [BASE_W-1:0]    cfg_data
);

    // Wake a channel: an idle channel turns on with its base period, an
    // active one bumps its pending count up to the cap.
    function automatic chan_t chan_wake(chan_t c, logic [BASE_W-1:0] base);
        chan_t r;
        r = c;
        if (c.on) begin
            if (c.ext < EXT_W'(INTERNAL_MAX)) begin
                r.ext = c.ext + EXT_W'(1);
            end
        end else begin
            r.on  = 1'b1;
            r.cnt = CNT_W'(base);
        end
        return r;
    endfunction

    // Tick a channel: count down, and on expiry either reload with
    // base * total pending or turn off.
    function automatic chan_t chan_tick(chan_t c, logic [BASE_W-1:0] base,
                                        logic [SHARED_W-1:0] shared);
        chan_t              r;
        logic [TOT_W-1:0]   sh;
        logic [TOT_W-1:0]   total;
        logic [WIDE_W-1:0]  prod;
        r = c;
        if (c.on) begin
            if (c.cnt > CNT_W'(1)) begin
                r.cnt = c.cnt - CNT_W'(1);
            end else begin
                sh = TOT_W'(shared);
                if (sh > TOT_W'(SHARED_MAX)) begin
                    sh = TOT_W'(SHARED_MAX);
                end
                total = TOT_W'(c.ext) + sh;
                if (total != '0) begin
                    prod = WIDE_W'(base) * WIDE_W'(total);
                    r.cnt = (prod > WIDE_W'(CNT_MAX)) ? CNT_MAX : prod[CNT_W-1:0];
                end else begin
                    r.on  = 1'b0;
                    r.cnt = '0;
                end
                r.ext = '0;
            end
        end
        return r;
    endfunction

    logic [BASE_W-1:0] core_base_reg;
    logic [BASE_W-1:0] input_base_reg;
    logic              susp_reg;
    logic              susp_next;
    chan_t             chan_reg  [2];
    chan_t             chan_next [2];

    out_item_t         out_reg;
    logic              out_valid_reg;
    out_item_t         skid_reg;
    logic              skid_valid_reg;
    out_item_t         res;

    logic              in_fire;
    logic              out_fire;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out       = out_reg;
    assign out_valid = out_valid_reg;

    // Config registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_base_reg  <= BASE_RESET;
            input_base_reg <= BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CORE_BASE:  core_base_reg  <= cfg_data;
                CFG_INPUT_BASE: input_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state for one event.
    always_comb
    begin
        susp_next    = susp_reg;
        chan_next[0] = chan_reg[0];
        chan_next[1] = chan_reg[1];
        if (in_fire)
        begin
            unique case (in.mode)
                MODE_TOUCH:
                begin
                    if (!susp_reg)
                    begin
                        chan_next[0] = chan_wake(chan_reg[0], core_base_reg);
                        chan_next[1] = chan_wake(chan_reg[1], input_base_reg);
                    end
                end
                MODE_TICK:
                begin
                    if (!susp_reg)
                    begin
                        chan_next[0] = chan_tick(chan_reg[0], core_base_reg,
                                                 in.shared_pending_core);
                        chan_next[1] = chan_tick(chan_reg[1], input_base_reg,
                                                 in.shared_pending_input);
                    end
                end
                MODE_BLANK:
                begin
                    if (!susp_reg)
                    begin
                        susp_next    = 1'b1;
                        chan_next[0] = '0;
                        chan_next[1] = '0;
                    end
                end
                MODE_UNBLANK:
                begin
                    if (susp_reg)
                    begin
                        susp_next    = 1'b0;
                        chan_next[0] = chan_wake(chan_reg[0], core_base_reg);
                        chan_next[1] = chan_wake(chan_reg[1], input_base_reg);
                    end
                end
                default: ;
            endcase
        end
        res.core_active    = chan_next[0].on;
        res.input_active   = chan_next[1].on;
        res.suspended_flag = susp_next;
    end

    // Timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            susp_reg    <= 1'b0;
            chan_reg[0] <= '0;
            chan_reg[1] <= '0;
        end
        else
        begin
            susp_reg    <= susp_next;
            chan_reg[0] <= chan_next[0];
            chan_reg[1] <= chan_next[1];
        end
    end

    // Output register and skid: when the output is empty or drains, advance the
    // skid into it, or else a new result; otherwise park a new result in the skid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (in_fire)
        begin
            skid_reg <= res;
        end
    end

    `ABET_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `ABET_ASSERT_IMPL(a_suspend_all_off, susp_reg, !chan_reg[0].on && !chan_reg[1].on)
    `ABET_ASSERT_ALWAYS(a_core_ext_capped, chan_reg[0].ext <= EXT_W'(INTERNAL_MAX))
    `ABET_ASSERT_ALWAYS(a_input_ext_capped, chan_reg[1].ext <= EXT_W'(INTERNAL_MAX))
    `ABET_ASSERT_IMPL(a_off_no_pending, !chan_reg[0].on, chan_reg[0].ext == '0)

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb
    import abet_pkg::*;
;

    // Channel numbering inside the tracker; core first, as the block has it.
    localparam int CORE_CH  = 0;
    localparam int INPUT_CH = 1;

    // Cycles with no beat on any channel before the run is declared hung.
    // The longest quiet stretch is the long receiver hold-off plus a sender
    // gap and a receiver burst; take that several times over.
    localparam int HANG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;

    // Tracks the timer state beat by beat and keeps the flags each
    // accepted event must produce, oldest first.
    class boost_flags_board;
        logic [BASE_W-1:0] base_ticks [2];
        logic              suspended;
        logic              on [2];
        logic [EXT_W-1:0]  ext [2];
        logic [CNT_W-1:0]  cnt [2];
        out_item_t         flags_due [$];
        int unsigned       errors;

        function new();
            base_ticks[CORE_CH]  = BASE_RESET;
            base_ticks[INPUT_CH] = BASE_RESET;
            suspended = 1'b0;
            for (int ch = 0; ch < 2; ch++)
            begin
                on[ch]  = 1'b0;
                ext[ch] = '0;
                cnt[ch] = '0;
            end
            errors = 0;
        endfunction

        function void set_base(cfg_idx_t idx, logic [BASE_W-1:0] value);
            if (idx == CFG_CORE_BASE)
                base_ticks[CORE_CH] = value;
            else
                base_ticks[INPUT_CH] = value;
        endfunction

        function int pending();
            return flags_due.size();
        endfunction

        // Touch or unblank: start idle channels, extend running ones.
        function void wake_channels();
            for (int ch = 0; ch < 2; ch++)
            begin
                if (on[ch])
                begin
                    if (ext[ch] < INTERNAL_MAX)
                        ext[ch] = ext[ch] + 1'b1;
                end
                else
                begin
                    on[ch]  = 1'b1;
                    cnt[ch] = CNT_W'(base_ticks[ch]);
                end
            end
        endfunction

        function void tick_channel(int ch, logic [SHARED_W-1:0] shared_cnt);
            int unsigned shared_eff;
            int unsigned total;
            int unsigned product;
            if (!on[ch])
                return;
            if (cnt[ch] > 1)
            begin
                cnt[ch] = cnt[ch] - 1'b1;
                return;
            end
            // Expiry: clamp the shared count, then reload or drop the channel.
            shared_eff = (shared_cnt > SHARED_MAX) ? SHARED_MAX : int'(shared_cnt);
            total = int'(ext[ch]) + shared_eff;
            if (total > 0)
            begin
                product = int'(base_ticks[ch]) * total;
                cnt[ch] = (product > CNT_MAX) ? CNT_MAX : CNT_W'(product);
            end
            else
            begin
                on[ch]  = 1'b0;
                cnt[ch] = '0;
            end
            ext[ch] = '0;
        endfunction

        function void note_event(in_item_t ev);
            out_item_t want;
            case (ev.mode)
                MODE_TOUCH:
                begin
                    if (!suspended)
                        wake_channels();
                end
                MODE_TICK:
                begin
                    if (!suspended)
                    begin
                        tick_channel(CORE_CH, ev.shared_pending_core);
                        tick_channel(INPUT_CH, ev.shared_pending_input);
                    end
                end
                MODE_BLANK:
                begin
                    if (!suspended)
                    begin
                        suspended = 1'b1;
                        for (int ch = 0; ch < 2; ch++)
                        begin
                            on[ch]  = 1'b0;
                            ext[ch] = '0;
                            cnt[ch] = '0;
                        end
                    end
                end
                default:
                begin
                    if (suspended)
                    begin
                        suspended = 1'b0;
                        wake_channels();
                    end
                end
            endcase
            want.core_active    = on[CORE_CH];
            want.input_active   = on[INPUT_CH];
            want.suspended_flag = suspended;
            flags_due.push_back(want);
        endfunction

        function void check_flags(out_item_t got);
            out_item_t want;
            if (flags_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %b", $time, got);
                errors++;
                return;
            end
            want = flags_due.pop_front();
            if (got.core_active !== want.core_active)
            begin
                $display("%0t: core_active mismatch, expected %b actual %b",
                         $time, want.core_active, got.core_active);
                errors++;
            end
            if (got.input_active !== want.input_active)
            begin
                $display("%0t: input_active mismatch, expected %b actual %b",
                         $time, want.input_active, got.input_active);
                errors++;
            end
            if (got.suspended_flag !== want.suspended_flag)
            begin
                $display("%0t: suspended_flag mismatch, expected %b actual %b",
                         $time, want.suspended_flag, got.suspended_flag);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    in_item_t          in;
    logic              in_valid;
    logic              in_stall;
    out_item_t         out;
    logic              out_valid;
    logic              out_stall;
    logic              cfg_valid;
    logic              cfg_ready;
    cfg_idx_t          cfg_index;
    logic [BASE_W-1:0] cfg_data;

    boost_flags_board board;

    // Shared control between the stimulus and the receiver.
    bit long_hold = 1'b0;   // request one long receiver hold-off
    bit quiet     = 1'b0;   // final part of the run: no idling on either side

    activity_boost_extend_timer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out       (out),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Monitor both channels at the edge. Check the result beat first, then
    // record the input beat, so an event accepted at this edge can never
    // be matched against a result leaving at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_flags(out);
            if (in_valid && !in_stall)
                board.note_event(in);
        end
    end

    // Watchdog: count cycles with no beat on any channel; bail out on a hang.
    initial
    begin : hang_watch
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat for %0d cycles", $time, HANG_LIMIT);
        $display("activity_boost_extend_timer_top regression: fail");
        $finish;
    end

    // Receiver: stall in random bursts, serve the long hold-off on request,
    // and stay open once the run goes quiet.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                // Hold off long enough that the output stage fills and the
                // block pushes back on the sender.
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic in_item_t make_event(mode_t mode, int core_sh, int input_sh);
        in_item_t ev;
        ev.mode                 = mode;
        ev.shared_pending_core  = SHARED_W'(core_sh);
        ev.shared_pending_input = SHARED_W'(input_sh);
        return ev;
    endfunction

    // Ticks dominate so channels expire often; shared counts lean to zero so
    // expiries also drop channels, and run up to the field max to hit clamping.
    function automatic in_item_t random_event();
        in_item_t    ev;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            ev.mode = MODE_TICK;
        else if (pick < 80)
            ev.mode = MODE_TOUCH;
        else if (pick < 88)
            ev.mode = MODE_BLANK;
        else
            ev.mode = MODE_UNBLANK;
        ev.shared_pending_core  = $urandom_range(0, 1) ? '0 :
                                  SHARED_W'($urandom_range(0, (1 << SHARED_W) - 1));
        ev.shared_pending_input = $urandom_range(0, 1) ? '0 :
                                  SHARED_W'($urandom_range(0, (1 << SHARED_W) - 1));
        return ev;
    endfunction

    // Offer one event beat and hold it until accepted. Insert a random gap
    // first unless the run is quiet or a flood is under way.
    task automatic offer_event(in_item_t ev, bit no_gap);
        if (!quiet && !no_gap && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in       <= ev;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Write both base periods; cfg_valid stays high across the two beats.
    task automatic write_bases(logic [BASE_W-1:0] core_base, logic [BASE_W-1:0] input_base);
        cfg_index <= CFG_CORE_BASE;
        cfg_data  <= core_base;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_base(CFG_CORE_BASE, core_base);
        cfg_index <= CFG_INPUT_BASE;
        cfg_data  <= input_base;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_base(CFG_INPUT_BASE, input_base);
        cfg_valid <= 1'b0;
    endtask

    // Drop the sender and drain every expected result, then let the clock run
    // on before touching the registers.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic run_random(int count, bit with_hold);
        int flood;
        flood = 0;
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == count / 2)
            begin
                // Start the long hold-off and keep offering back to back.
                long_hold = 1'b1;
                flood = 40;
            end
            offer_event(random_event(), flood != 0);
            if (flood != 0)
                flood--;
        end
    endtask

    // Directed events, run with both base periods at one so that every
    // channel started from idle expires on the next tick.
    task automatic run_directed();
        // Unblank while awake: ignored.
        offer_event(make_event(MODE_UNBLANK, 0, 0), 1'b0);
        // Touch an idle block: both channels start.
        offer_event(make_event(MODE_TOUCH, 0, 0), 1'b0);
        // Touch running channels until the extension count saturates.
        repeat (6) offer_event(make_event(MODE_TOUCH, 0, 0), 1'b0);
        // Expire with field-max shared counts: clamp, then reload.
        offer_event(make_event(MODE_TICK, 7, 7), 1'b0);
        offer_event(make_event(MODE_TICK, 0, 0), 1'b0);
        offer_event(make_event(MODE_BLANK, 0, 0), 1'b0);
        // Suspended: touch, tick and a second blank are all ignored.
        offer_event(make_event(MODE_TOUCH, 7, 7), 1'b0);
        offer_event(make_event(MODE_TICK, 7, 7), 1'b0);
        offer_event(make_event(MODE_BLANK, 0, 0), 1'b0);
        // Unblank wakes both channels.
        offer_event(make_event(MODE_UNBLANK, 0, 0), 1'b0);
        // Expire with nothing pending: both drop.
        offer_event(make_event(MODE_TICK, 0, 0), 1'b0);
        offer_event(make_event(MODE_TOUCH, 0, 0), 1'b0);
        // Core reloads at the clamp value, input drops.
        offer_event(make_event(MODE_TICK, 5, 0), 1'b0);
        offer_event(make_event(MODE_TOUCH, 6, 3), 1'b0);
        offer_event(make_event(MODE_TICK, 0, 6), 1'b0);
        offer_event(make_event(MODE_TICK, 2, 1), 1'b0);
        offer_event(make_event(MODE_TICK, 4, 4), 1'b0);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in        = '0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CORE_BASE;
        cfg_data  = '0;
        board     = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset base periods first.
        run_random(200, 1'b0);

        settle();
        write_bases(BASE_W'(1), BASE_W'(1));
        run_directed();
        run_random(250, 1'b0);

        // Zero base period on the core: active channel with an empty countdown.
        settle();
        write_bases(BASE_W'(0), BASE_W'(2));
        run_random(250, 1'b0);

        // Largest base periods, one channel at a time.
        settle();
        write_bases(BASE_W'(3), '1);
        run_random(200, 1'b0);

        settle();
        write_bases('1, BASE_W'(1));
        run_random(200, 1'b0);

        // Small random periods, with the long receiver hold-off mid-phase.
        settle();
        write_bases(BASE_W'($urandom_range(1, 6)), BASE_W'($urandom_range(1, 6)));
        run_random(250, 1'b1);

        // Last part: no idling on either side.
        settle();
        quiet = 1'b1;
        write_bases(BASE_W'(2), BASE_W'(5));
        run_random(400, 1'b0);

        settle();
        repeat (5) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("activity_boost_extend_timer_top regression: pass");
        else
            $display("activity_boost_extend_timer_top regression: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/abet_pkg.sv
rtl/activity_boost_extend_timer_top.sv
verif/tb.sv
